/* sv/cskn_pkg.sv */
package cskn_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned CoordW = 32;
  localparam int unsigned SlotIdxW = 2;
  localparam int unsigned ColW = 64;
  localparam int unsigned DistW = 64;

  // Affine column layout: three Q4.12 coefficients then a Q8.8 offset
  localparam int unsigned CoefW = 16;
  // Q.28 product reduced to Q16.16
  localparam int unsigned FracShift = 12;
  // Q8.8 offset lifted to Q.28
  localparam int unsigned OffsetShift = 20;

  // Key reset value: most negative Q16.16
  localparam logic [CoordW-1:0] KEY_RESET = {1'b1, {(CoordW-1){1'b0}}};
  // One unit of depth in Q16.16, widened for the guard compare
  localparam logic signed [CoordW:0] DEPTH_MARGIN = 33'sd65536;

  typedef enum logic [1:0] {
    CFG_COLUMN_X,
    CFG_COLUMN_Y,
    CFG_COLUMN_Z,
    CFG_REF_DEPTH
  } cfg_idx_e;

  typedef struct packed {
    logic [SlotIdxW-1:0]      slot_index;
    logic signed [CoordW-1:0] cand_x;
    logic signed [CoordW-1:0] cand_y;
    logic signed [CoordW-1:0] cand_z;
    logic signed [CoordW-1:0] cand_key_x;
    logic signed [CoordW-1:0] cand_key_y;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
  } cskn_in_t;

  typedef struct packed {
    logic                     replaced;
    logic [SlotIdxW-1:0]      slot_echo;
    logic signed [CoordW-1:0] stored_x;
    logic signed [CoordW-1:0] stored_y;
    logic signed [CoordW-1:0] stored_z;
    logic                     slot_filled;
  } cskn_out_t;

  // Contents of the addressed slot
  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] key_x;
    logic signed [CoordW-1:0] key_y;
    logic                     filled;
  } slot_rd_t;

  // Update to one slot
  typedef struct packed {
    logic                     en;
    logic [SlotIdxW-1:0]      idx;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] key_x;
    logic signed [CoordW-1:0] key_y;
  } slot_wr_t;

endpackage

/* sv/cskn_affine.sv */
module cskn_affine
  import cskn_pkg::*;
(
  input  logic [ColW-1:0]          col_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  logic signed [CoordW-1:0] pz_i,
  output logic signed [CoordW-1:0] val_o
);

  localparam int unsigned ProdW = CoefW + CoordW;
  localparam int unsigned AccW = ProdW + 3;
  localparam int unsigned ShW = AccW - FracShift;

  logic signed [CoefW-1:0]                 cx, cy, cz, co;
  logic signed [ProdW-1:0]                 mx, my, mz;
  logic signed [CoefW+OffsetShift-1:0]     off;
  logic signed [AccW-1:0]                  acc;
  logic signed [ShW-1:0]                   sh;
  logic                                    ovf;

  // Unpack the column
  assign cx = col_i[CoefW-1:0];
  assign cy = col_i[2*CoefW-1:CoefW];
  assign cz = col_i[3*CoefW-1:2*CoefW];
  assign co = col_i[4*CoefW-1:3*CoefW];

  // Q4.12 x Q16.16 products
  assign mx = ProdW'(cx) * ProdW'(px_i);
  assign my = ProdW'(cy) * ProdW'(py_i);
  assign mz = ProdW'(cz) * ProdW'(pz_i);
  assign off = {co, {OffsetShift{1'b0}}};

  assign acc = AccW'(mx) + AccW'(my) + AccW'(mz) + AccW'(off);

  // Arithmetic shift: floor towards minus infinity
  assign sh = acc[AccW-1:FracShift];

  // Saturate to signed 32 bits
  assign ovf = (sh[ShW-1:CoordW-1] != {(ShW-CoordW+1){1'b0}}) &&
               (sh[ShW-1:CoordW-1] != {(ShW-CoordW+1){1'b1}});

  always_comb begin
    if (!ovf) begin
      val_o = sh[CoordW-1:0];
    end else if (sh[ShW-1]) begin
      val_o = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      val_o = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

endmodule

/* sv/cskn_sqdist.sv */
module cskn_sqdist
  import cskn_pkg::*;
(
  input  logic signed [CoordW-1:0] kx_i,
  input  logic signed [CoordW-1:0] ky_i,
  input  logic signed [CoordW-1:0] tx_i,
  input  logic signed [CoordW-1:0] ty_i,
  output logic [DistW-1:0]         dist_o
);

  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]        ndx, ndy;
  logic [CoordW-1:0]      ax, ay;
  logic [DistW-1:0]       sx, sy;
  logic [DistW:0]         sum;

  // Exact differences; magnitude always fits in 32 bits
  assign dx  = (CoordW+1)'(kx_i) - (CoordW+1)'(tx_i);
  assign dy  = (CoordW+1)'(ky_i) - (CoordW+1)'(ty_i);
  assign ndx = -dx;
  assign ndy = -dy;
  assign ax  = dx[CoordW] ? ndx[CoordW-1:0] : dx[CoordW-1:0];
  assign ay  = dy[CoordW] ? ndy[CoordW-1:0] : dy[CoordW-1:0];

  assign sx  = DistW'(ax) * DistW'(ax);
  assign sy  = DistW'(ay) * DistW'(ay);

  // Saturating sum
  assign sum    = {1'b0, sx} + {1'b0, sy};
  assign dist_o = sum[DistW] ? {DistW{1'b1}} : sum[DistW-1:0];

endmodule

/* sv/cskn_slots.sv */
module cskn_slots
  import cskn_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SlotIdxW-1:0] idx_i,
  input  slot_wr_t            wr_i,
  output slot_rd_t            rd_o
);

  logic [CoordW-1:0] pos_x_q [SLOT_COUNT];
  logic [CoordW-1:0] pos_y_q [SLOT_COUNT];
  logic [CoordW-1:0] pos_z_q [SLOT_COUNT];
  logic [CoordW-1:0] key_x_q [SLOT_COUNT];
  logic [CoordW-1:0] key_y_q [SLOT_COUNT];
  logic              flag_q  [SLOT_COUNT];

  // Slot store, at most one row written per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pos_x_q[i] <= '0;
        pos_y_q[i] <= '0;
        pos_z_q[i] <= '0;
        key_x_q[i] <= KEY_RESET;
        key_y_q[i] <= KEY_RESET;
        flag_q[i]  <= 1'b0;
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (int'(wr_i.idx) == i) begin
          pos_x_q[i] <= wr_i.pos_x;
          pos_y_q[i] <= wr_i.pos_y;
          pos_z_q[i] <= wr_i.pos_z;
          key_x_q[i] <= wr_i.key_x;
          key_y_q[i] <= wr_i.key_y;
          flag_q[i]  <= 1'b1;
        end
      end
    end
  end

  // Read of the addressed slot; an index past the last slot reads as all zero
  always_comb begin
    rd_o = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (int'(idx_i) == i) begin
        rd_o.hit    = 1'b1;
        rd_o.pos_x  = pos_x_q[i];
        rd_o.pos_y  = pos_y_q[i];
        rd_o.pos_z  = pos_z_q[i];
        rd_o.key_x  = key_x_q[i];
        rd_o.key_y  = key_y_q[i];
        rd_o.filled = flag_q[i];
      end
    end
  end

endmodule

/* sv/corner_slot_keep_nearest.sv */
// Corner slot keeper. A candidate is taken on any rising edge with start high
// (busy never rises, so one transaction per cycle is sustained); it is held in
// the input register, and its result is captured in the result register and
// shown on res_o with done_o high for exactly one cycle. The receiver cannot
// stall: every result must be taken in the cycle it is shown. All distance,
// transform and guard logic runs in one pass between the input register and
// the result register, and the slot it touches is updated at the same edge, so
// a following candidate for the same slot already sees it. Configuration
// writes take effect at the edge they are made on and are only to be made
// while no transaction is in flight.
module corner_slot_keep_nearest
  import cskn_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [ColW-1:0]     cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  cskn_in_t            in_i,
  output logic                done_o,
  output cskn_out_t           res_o
);

  logic [ColW-1:0]          col_x_q, col_y_q, col_z_q;
  logic signed [CoordW-1:0] ref_depth_q;
  cskn_in_t                 in_q;
  logic                     in_vld_q;
  cskn_out_t                res_q, res_d;
  logic                     done_q;

  slot_rd_t                 rd;
  slot_wr_t                 wr;
  logic [DistW-1:0]         cand_dist, inc_dist;
  logic signed [CoordW-1:0] ox, oy, oz;
  logic                     nearer, depth_ok, take;

  // Never backpressures
  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_x_q     <= '0;
      col_y_q     <= '0;
      col_z_q     <= '0;
      ref_depth_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COLUMN_X:  col_x_q     <= cfg_wdata_i;
        CFG_COLUMN_Y:  col_y_q     <= cfg_wdata_i;
        CFG_COLUMN_Z:  col_z_q     <= cfg_wdata_i;
        CFG_REF_DEPTH: ref_depth_q <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= in_i;
    end
  end

  cskn_slots #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slots (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .idx_i (in_q.slot_index),
    .wr_i  (wr),
    .rd_o  (rd)
  );

  // Candidate and incumbent key distances
  cskn_sqdist u_dist_cand (
    .kx_i  (in_q.cand_key_x),
    .ky_i  (in_q.cand_key_y),
    .tx_i  (in_q.target_x),
    .ty_i  (in_q.target_y),
    .dist_o(cand_dist)
  );

  cskn_sqdist u_dist_inc (
    .kx_i  (rd.key_x),
    .ky_i  (rd.key_y),
    .tx_i  (in_q.target_x),
    .ty_i  (in_q.target_y),
    .dist_o(inc_dist)
  );

  // Affine transform, one unit per output column
  cskn_affine u_aff_x (
    .col_i(col_x_q),
    .px_i (in_q.cand_x),
    .py_i (in_q.cand_y),
    .pz_i (in_q.cand_z),
    .val_o(ox)
  );

  cskn_affine u_aff_y (
    .col_i(col_y_q),
    .px_i (in_q.cand_x),
    .py_i (in_q.cand_y),
    .pz_i (in_q.cand_z),
    .val_o(oy)
  );

  cskn_affine u_aff_z (
    .col_i(col_z_q),
    .px_i (in_q.cand_x),
    .py_i (in_q.cand_y),
    .pz_i (in_q.cand_z),
    .val_o(oz)
  );

  // Keep decision: strictly nearer and not too deep; ties keep the incumbent
  assign nearer   = cand_dist < inc_dist;
  assign depth_ok = (CoordW+1)'(oz) <= ((CoordW+1)'(ref_depth_q) + DEPTH_MARGIN);
  assign take     = rd.hit & nearer & depth_ok;

  // Slot update
  always_comb begin
    wr.en    = in_vld_q & take;
    wr.idx   = in_q.slot_index;
    wr.pos_x = ox;
    wr.pos_y = oy;
    wr.pos_z = oz;
    wr.key_x = in_q.cand_key_x;
    wr.key_y = in_q.cand_key_y;
  end

  // Result: slot contents after this transaction
  always_comb begin
    res_d.replaced    = take;
    res_d.slot_echo   = in_q.slot_index;
    res_d.stored_x    = take ? ox : rd.pos_x;
    res_d.stored_y    = take ? oy : rd.pos_y;
    res_d.stored_z    = take ? oz : rd.pos_z;
    res_d.slot_filled = take | rd.filled;
  end

  // Result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* dv/tb_top.sv */
module tb_top;
  import cskn_pkg::*;

  localparam logic [CoordW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] Q_MIN = 32'h8000_0000;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 100;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [ColW-1:0]   cfg_wdata_i;
  logic              start;
  logic              busy;
  cskn_in_t          in_i;
  logic              done_o;
  cskn_out_t         res_o;

  corner_slot_keep_nearest dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  // Local copy of the slot store and the registers
  logic signed [CoordW-1:0] slot_x_m   [4];
  logic signed [CoordW-1:0] slot_y_m   [4];
  logic signed [CoordW-1:0] slot_z_m   [4];
  logic signed [CoordW-1:0] slot_kx_m  [4];
  logic signed [CoordW-1:0] slot_ky_m  [4];
  logic                     slot_full_m[4];
  logic [ColW-1:0]          col_x_m, col_y_m, col_z_m;
  logic signed [CoordW-1:0] ref_depth_m;

  // Slot reports still to come, oldest first
  cskn_out_t slot_report_q[$];

  int unsigned fail_count;
  int unsigned stall_cycles;
  int unsigned idle_pct;
  logic [CoordW-1:0] fresh_key;
  logic [CoordW-1:0] aim_x[4];
  logic [CoordW-1:0] aim_y[4];
  cskn_out_t want;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Affine column applied to a Q16.16 point, floor shift then saturate
  function automatic longint affine_q16(logic [ColW-1:0] col, longint px, longint py,
                                        longint pz);
    logic signed [CoefW-1:0] cx, cy, cz, co;
    longint acc;
    cx = col[15:0];
    cy = col[31:16];
    cz = col[47:32];
    co = col[63:48];
    acc = longint'(cx) * px + longint'(cy) * py + longint'(cz) * pz
        + longint'(co) * 64'sd1048576;
    acc = acc >>> FracShift;
    if (acc > 64'sd2147483647) return 64'sd2147483647;
    if (acc < -64'sd2147483648) return -64'sd2147483648;
    return acc;
  endfunction

  // Squared key distance, saturating at all ones
  function automatic logic [DistW-1:0] key_dist_sq(longint kx, longint ky, longint tx,
                                                   longint ty);
    longint dx, dy;
    logic [DistW-1:0] ax, ay;
    logic [DistW:0] s;
    dx = kx - tx;
    dy = ky - ty;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    s = {1'b0, ax * ax} + {1'b0, ay * ay};
    if (s[DistW]) return '1;
    return s[DistW-1:0];
  endfunction

  // Works out the report for one candidate and updates the slot copy
  function automatic cskn_out_t predict_slot_update(cskn_in_t t);
    cskn_out_t r;
    int s;
    longint px, py, pz, kx, ky, tx, ty, ox, oy, oz, lim, ik, jk;
    s = t.slot_index;
    px = t.cand_x;
    py = t.cand_y;
    pz = t.cand_z;
    kx = t.cand_key_x;
    ky = t.cand_key_y;
    tx = t.target_x;
    ty = t.target_y;
    ik = slot_kx_m[s];
    jk = slot_ky_m[s];
    lim = ref_depth_m;
    lim = lim + 65536;
    r = '0;
    r.slot_echo = t.slot_index;
    if (key_dist_sq(kx, ky, tx, ty) < key_dist_sq(ik, jk, tx, ty)) begin
      oz = affine_q16(col_z_m, px, py, pz);
      if (oz <= lim) begin
        ox = affine_q16(col_x_m, px, py, pz);
        oy = affine_q16(col_y_m, px, py, pz);
        slot_x_m[s] = ox[31:0];
        slot_y_m[s] = oy[31:0];
        slot_z_m[s] = oz[31:0];
        slot_kx_m[s] = t.cand_key_x;
        slot_ky_m[s] = t.cand_key_y;
        slot_full_m[s] = 1'b1;
        r.replaced = 1'b1;
      end
    end
    r.stored_x = slot_x_m[s];
    r.stored_y = slot_y_m[s];
    r.stored_z = slot_z_m[s];
    r.slot_filled = slot_full_m[s];
    return r;
  endfunction

  function automatic cskn_in_t make_item(logic [1:0] slot, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz, logic [31:0] kx, logic [31:0] ky,
                                         logic [31:0] tx, logic [31:0] ty);
    cskn_in_t t;
    t.slot_index = slot;
    t.cand_x = px;
    t.cand_y = py;
    t.cand_z = pz;
    t.cand_key_x = kx;
    t.cand_key_y = ky;
    t.target_x = tx;
    t.target_y = ty;
    return t;
  endfunction

  // Key sitting on a target never used before, so the candidate is always nearer
  function automatic cskn_in_t nearest_item(logic [1:0] slot, logic [31:0] px,
                                            logic [31:0] py, logic [31:0] pz);
    fresh_key = fresh_key + 32'h0001_0001;
    return make_item(slot, px, py, pz, fresh_key, ~fresh_key, fresh_key, ~fresh_key);
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2, 3, 4, 5, 6: begin
        v = $urandom_range(0, 32'h0020_0000);
        v = v - 32'h0010_0000;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_coef();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h0000;
      1: v = 16'h1000;
      2: v = 16'h7FFF;
      3: v = 16'h8000;
      4: v = 16'($urandom_range(0, 16'h1FFF)) - 16'h1000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Half the candidates near a per-slot target, some ties and some noise
  function automatic cskn_in_t random_item();
    logic [1:0] s;
    logic [31:0] tx, ty, kx, ky, d;
    int unsigned pick;
    s = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      aim_x[s] = rand_coord();
      aim_y[s] = rand_coord();
    end
    if ($urandom_range(0, 9) < 7) begin
      tx = aim_x[s];
      ty = aim_y[s];
    end else begin
      tx = rand_coord();
      ty = rand_coord();
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      d = $urandom_range(0, 600);
      kx = tx + d - 32'd300;
      d = $urandom_range(0, 600);
      ky = ty + d - 32'd300;
    end else if (pick < 60) begin
      kx = slot_kx_m[s];
      ky = slot_ky_m[s];
    end else begin
      kx = rand_coord();
      ky = rand_coord();
    end
    return make_item(s, rand_coord(), rand_coord(), rand_coord(), kx, ky, tx, ty);
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      in_i <= make_item(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
    end
  endtask

  // One transaction; start stays high so the next one can follow at once
  task automatic send_item(cskn_in_t t);
    while ($urandom_range(0, 99) < idle_pct) idle_cycles(1);
    @(negedge clk_i);
    start <= 1'b1;
    in_i <= t;
    do @(posedge clk_i); while (busy);
    slot_report_q.push_back(predict_slot_update(t));
  endtask

  // Stop sending and let every outstanding report arrive
  task automatic wait_quiet();
    @(negedge clk_i);
    start <= 1'b0;
    while (slot_report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [ColW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_COLUMN_X:  col_x_m = data;
      CFG_COLUMN_Y:  col_y_m = data;
      CFG_COLUMN_Z:  col_z_m = data;
      CFG_REF_DEPTH: ref_depth_m = data[31:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [ColW-1:0] cx, logic [ColW-1:0] cy, logic [ColW-1:0] cz,
                            logic [31:0] rd);
    wait_quiet();
    write_reg(CFG_COLUMN_X, cx);
    write_reg(CFG_COLUMN_Y, cy);
    write_reg(CFG_COLUMN_Z, cz);
    write_reg(CFG_REF_DEPTH, {32'($urandom), rd});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reset registers: distance ties, saturated distances, first fills
  task automatic test_reset_slots();
    send_item(make_item(2'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_item(make_item(2'd1, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
    send_item(make_item(2'd2, Q_MAX, Q_MAX, Q_MAX, Q_MIN + 1, Q_MIN, Q_MAX, Q_MAX));
    send_item(make_item(2'd2, Q_MAX, Q_MAX, Q_MAX, 32'd0, 32'd0, Q_MAX, Q_MAX));
    send_item(make_item(2'd3, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 32'd0, 32'd0));
    send_item(make_item(2'd0, 32'd1, -32'd1, 32'd0, 32'd5, -32'd7, 32'd5, -32'd7));
    send_item(make_item(2'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0));
    send_item(make_item(2'd1, 32'd0, 32'd0, 32'd0, -32'd1, 32'd1, 32'd0, 32'd0));
    send_item(make_item(2'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
  endtask

  // Largest and most negative coefficients drive both saturation limits
  task automatic test_transform_saturation();
    set_config(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
               64'h0000_1000_0000_0000, Q_MAX);
    send_item(nearest_item(2'd0, Q_MAX, Q_MAX, Q_MAX));
    send_item(nearest_item(2'd1, Q_MIN, Q_MIN, Q_MIN));
    send_item(nearest_item(2'd2, Q_MIN, Q_MAX, 32'd0));
    send_item(nearest_item(2'd3, 32'd1, -32'd1, 32'h0001_0000));
  endtask

  // Depth exactly at the limit, one past it, floor rounding, lowest reference
  task automatic test_depth_guard();
    set_config(64'h0000_0000_0000_0001, 64'hFF80_0000_0000_0000,
               64'h0000_1000_0000_0000, 32'hFFFD_0000);
    send_item(nearest_item(2'd0, -32'd1, 32'd0, 32'hFFFE_0000));
    send_item(nearest_item(2'd1, 32'd7, 32'd0, 32'hFFFE_0001));
    send_item(nearest_item(2'd2, 32'd4095, 32'd0, 32'hFFFD_FFFF));
    set_config(64'h0000_0000_0000_0001, 64'hFF80_0000_0000_0000,
               64'h0000_1000_0000_0000, Q_MIN);
    send_item(nearest_item(2'd3, 32'd4096, Q_MAX, Q_MIN));
    send_item(nearest_item(2'd3, 32'd1, Q_MIN, 32'h8001_0001));
  endtask

  // Random stream over several register settings
  task automatic test_random_stream();
    logic [31:0] rd;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        3:       rd = Q_MAX;
        4:       rd = Q_MIN;
        default: rd = rand_coord();
      endcase
      set_config({rand_coef(), rand_coef(), rand_coef(), rand_coef()},
                 {rand_coef(), rand_coef(), rand_coef(), rand_coef()},
                 {rand_coef(), rand_coef(), rand_coef(), rand_coef()}, rd);
      // Phase one runs back to back with no gaps
      idle_pct = (ph == 1) ? 0 : 22;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_quiet();
        send_item(random_item());
      end
    end
    idle_pct = 22;
  endtask

  // Report check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (slot_report_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected report: slot %0d", res_o.slot_echo);
      end else begin
        want = slot_report_q.pop_front();
        if (res_o.replaced !== want.replaced || res_o.slot_echo !== want.slot_echo ||
            res_o.stored_x !== want.stored_x || res_o.stored_y !== want.stored_y ||
            res_o.stored_z !== want.stored_z || res_o.slot_filled !== want.slot_filled) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch exp: rep %0d slot %0d x %h y %h z %h full %0d", want.replaced,
                     want.slot_echo, want.stored_x, want.stored_y, want.stored_z,
                     want.slot_filled);
            $display("         got: rep %0d slot %0d x %h y %h z %h full %0d", res_o.replaced,
                     res_o.slot_echo, res_o.stored_x, res_o.stored_y, res_o.stored_z,
                     res_o.slot_filled);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction either way
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || cfg_we_i || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sequence
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COLUMN_X;
    cfg_wdata_i = '0;
    in_i = '0;
    fail_count = 0;
    stall_cycles = 0;
    idle_pct = 22;
    fresh_key = 32'h1234_0000;
    col_x_m = '0;
    col_y_m = '0;
    col_z_m = '0;
    ref_depth_m = '0;
    for (int i = 0; i < 4; i++) begin
      slot_x_m[i] = '0;
      slot_y_m[i] = '0;
      slot_z_m[i] = '0;
      slot_kx_m[i] = KEY_RESET;
      slot_ky_m[i] = KEY_RESET;
      slot_full_m[i] = 1'b0;
      aim_x[i] = $urandom;
      aim_y[i] = $urandom;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_slots();
    test_transform_saturation();
    test_depth_guard();
    test_random_stream();

    wait_quiet();
    if (fail_count == 0 && slot_report_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
